[sv/dbnc_pkg.sv]
// Shared types, codes and sizes for the multichannel debounce block.
// Used by every module in this folder; depends on nothing else.
package dbnc_pkg;

    // Number of debounced channels (1 to 255).
    localparam int CHANNEL_COUNT = 8;
    localparam int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [7:0] CHANNEL_LIMIT = 8'(CHANNEL_COUNT);

    localparam logic [7:0] THRESHOLD_RESET = 8'd10;

    // Per-channel phase codes.
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_FALL = 2'd3;

    typedef struct packed {
        logic [7:0] channel;
        logic       raw_level;
    } dbnc_in_t;

    typedef struct packed {
        logic stable_level;
        logic bad_channel;
    } dbnc_out_t;

    // Everything kept for one channel.
    typedef struct packed {
        logic       level;
        logic [7:0] count;
        logic [1:0] phase;
    } chan_state_t;

endpackage

[sv/dbnc_step.sv]
// One debounce step: next channel state from the current state and one sample.
// Depends on dbnc_pkg for the phase codes and the channel state type.
module dbnc_step (
    input  dbnc_pkg::chan_state_t cur,
    input  logic                  raw_level,
    input  logic [7:0]            threshold,
    output dbnc_pkg::chan_state_t nxt
);
    import dbnc_pkg::*;

    logic confirmed;

    assign confirmed = (cur.count >= threshold);

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            PH_LOW:
            begin
                if (raw_level)
                begin
                    nxt.count = 8'd1;
                    nxt.phase = PH_RISE;
                end
            end
            PH_HIGH:
            begin
                if (!raw_level)
                begin
                    nxt.count = 8'd1;
                    nxt.phase = PH_FALL;
                end
            end
            PH_RISE:
            begin
                // A low sample during a rise is noise and cancels it.
                if (!raw_level)
                begin
                    nxt.phase = PH_LOW;
                    nxt.count = 8'd0;
                end
                else if (confirmed)
                begin
                    nxt.level = 1'b1;
                    nxt.phase = PH_HIGH;
                end
                else
                begin
                    nxt.count = 8'(cur.count + 8'd1);
                end
            end
            PH_FALL:
            begin
                if (raw_level)
                begin
                    nxt.phase = PH_HIGH;
                    nxt.count = 8'd0;
                end
                else if (confirmed)
                begin
                    nxt.level = 1'b0;
                    nxt.phase = PH_LOW;
                end
                else
                begin
                    nxt.count = 8'(cur.count + 8'd1);
                end
            end
        endcase
    end

endmodule

[sv/dbnc_chan_bank.sv]
// Register bank holding the level, counter and phase of every channel.
// Depends on dbnc_pkg for the channel count and the channel state type.
module dbnc_chan_bank (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dbnc_pkg::CH_IDX_W-1:0]       rd_idx,
    output dbnc_pkg::chan_state_t               rd_state,
    input  logic                                wr_en,
    input  logic [dbnc_pkg::CH_IDX_W-1:0]       wr_idx,
    input  dbnc_pkg::chan_state_t               wr_state
);
    import dbnc_pkg::*;

    chan_state_t bank_reg [CHANNEL_COUNT];

    assign rd_state = bank_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                bank_reg[i] <= '{level: 1'b0, count: 8'd0, phase: PH_LOW};
            end
        end
        else if (wr_en)
        begin
            bank_reg[wr_idx] <= wr_state;
        end
    end

endmodule

[sv/multichannel_debounce_fsm.sv]
// Top level of the multichannel debounce block: input register, channel
// bank update and result register. Depends on dbnc_pkg, dbnc_step, dbnc_chan_bank.
//
//   Channel   Handshake                      Payload
//   sample    sample_valid / sample_ready    sample (channel, raw_level)
//   result    result_valid / result_ready    result (stable_level, bad_channel)
//   config    cfg_wr_en (no wait)            cfg_wr_data (confirm threshold)
//
// One request is accepted per cycle while the result side is not stalled; its
// result passes through the input register and then the result register.
// The rate is set by the single read-update-write of the channel bank, which
// completes in the cycle a request leaves the input register.
// Reset (rst_n, asynchronous, active low) puts every channel at stable low with
// a zero counter and loads the threshold with 10.
// A stalled result holds the whole pipeline; the input register still takes
// a request while it is empty or moving on.
module multichannel_debounce_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  dbnc_pkg::dbnc_in_t   sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output dbnc_pkg::dbnc_out_t  result,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data
);
    import dbnc_pkg::*;

    // Configuration register.
    logic [7:0] threshold_reg;

    // Input register stage.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    dbnc_in_t   s1_data_reg;

    // Result register stage.
    logic       result_valid_reg;
    logic       result_valid_next;
    dbnc_out_t  result_reg;
    dbnc_out_t  result_next;

    logic        advance;
    logic        bad;
    logic        bank_wr_en;
    chan_state_t cur_state;
    chan_state_t nxt_state;

    // The result register can take a new value when it is empty or being read.
    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = !s1_valid_reg || advance;

    // A channel at or above the channel count touches no state.
    assign bad        = (s1_data_reg.channel >= CHANNEL_LIMIT);
    assign bank_wr_en = s1_valid_reg && advance && !bad;

    dbnc_chan_bank u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (s1_data_reg.channel[CH_IDX_W-1:0]),
        .rd_state (cur_state),
        .wr_en    (bank_wr_en),
        .wr_idx   (s1_data_reg.channel[CH_IDX_W-1:0]),
        .wr_state (nxt_state)
    );

    dbnc_step u_step (
        .cur       (cur_state),
        .raw_level (s1_data_reg.raw_level),
        .threshold (threshold_reg),
        .nxt       (nxt_state)
    );

    always_comb
    begin
        s1_valid_next     = sample_ready ? sample_valid : s1_valid_reg;
        result_valid_next = advance ? s1_valid_reg : result_valid_reg;
        result_next.bad_channel  = bad;
        result_next.stable_level = bad ? 1'b0 : nxt_state.level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            s1_data_reg <= sample;
        end
        if (advance && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[tb/sv/tb_multichannel_debounce_fsm.sv]
// Self-checking testbench for multichannel_debounce_fsm: random and directed sample
// requests, random stalls on both sides, results compared against a behavioral predictor.
// Depends on dbnc_pkg and the multichannel_debounce_fsm RTL.
module tb_multichannel_debounce_fsm;

    timeunit 1ns;
    timeprecision 1ps;

    import dbnc_pkg::*;

    // Longest stretch without any accepted request before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Cycles the receiver holds off when asked to back up the pipeline.
    localparam int LONG_HOLD = 60;

    // Tracks the debounce state of every channel, predicts the result of each
    // accepted sample request and checks results in arrival order.
    class debounce_checker;
        logic [7:0] threshold;
        logic       levels[CHANNEL_COUNT];
        logic [7:0] counts[CHANNEL_COUNT];
        logic [1:0] phases[CHANNEL_COUNT];
        dbnc_out_t  pending[$];
        int         errors;

        function new();
            threshold = THRESHOLD_RESET;
            errors = 0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                levels[i] = 1'b0;
                counts[i] = 8'd0;
                phases[i] = PH_LOW;
            end
        endfunction

        function void note_sample(dbnc_in_t s);
            dbnc_out_t want;
            int        c;
            if (s.channel >= CHANNEL_LIMIT)
            begin
                want.stable_level = 1'b0;
                want.bad_channel  = 1'b1;
            end
            else
            begin
                c = s.channel;
                case (phases[c])
                    PH_LOW:
                    begin
                        if (s.raw_level)
                        begin
                            counts[c] = 8'd1;
                            phases[c] = PH_RISE;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (!s.raw_level)
                        begin
                            counts[c] = 8'd1;
                            phases[c] = PH_FALL;
                        end
                    end
                    PH_RISE:
                    begin
                        if (!s.raw_level)
                        begin
                            phases[c] = PH_LOW;
                            counts[c] = 8'd0;
                        end
                        else if (counts[c] >= threshold)
                        begin
                            levels[c] = 1'b1;
                            phases[c] = PH_HIGH;
                        end
                        else
                            counts[c] = counts[c] + 8'd1;
                    end
                    default:
                    begin
                        if (s.raw_level)
                        begin
                            phases[c] = PH_HIGH;
                            counts[c] = 8'd0;
                        end
                        else if (counts[c] >= threshold)
                        begin
                            levels[c] = 1'b0;
                            phases[c] = PH_LOW;
                        end
                        else
                            counts[c] = counts[c] + 8'd1;
                    end
                endcase
                want.stable_level = levels[c];
                want.bad_channel  = 1'b0;
            end
            pending.push_back(want);
        endfunction

        function void check_result(dbnc_out_t r);
            dbnc_out_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, got stable_level=%0b bad_channel=%0b",
                         $time, r.stable_level, r.bad_channel);
                return;
            end
            want = pending.pop_front();
            if (r.stable_level !== want.stable_level)
            begin
                errors++;
                $display("%0t: stable_level mismatch, expected %0b, actual %0b",
                         $time, want.stable_level, r.stable_level);
            end
            if (r.bad_channel !== want.bad_channel)
            begin
                errors++;
                $display("%0t: bad_channel mismatch, expected %0b, actual %0b",
                         $time, want.bad_channel, r.bad_channel);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       sample_valid;
    logic       sample_ready;
    dbnc_in_t   sample;
    logic       result_valid;
    logic       result_ready;
    dbnc_out_t  result;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    debounce_checker chk;

    // Set by the stimulus to request a long receiver hold-off; the receiver
    // process clears it once the hold-off is over.
    logic long_stall_req;
    // Final part of the run: neither side idles.
    logic calm;
    int   items_sent;
    int   quiet_cycles;

    multichannel_debounce_fsm DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Monitor: everything that is accepted at a rising edge is seen here, with the
    // values that were present just before the edge. The same block runs the
    // hang watchdog, which counts cycles in which no request moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                chk.note_sample(sample);
            if (result_valid && result_ready)
                chk.check_result(result);
        end
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("tb_multichannel_debounce_fsm: FAIL");
            $finish;
        end
    end

    // Receiver: drives result_ready at the falling edge. It stalls in random
    // bursts, sometimes runs for a while without stalling, and
    // on request holds off for a long stretch so that the block backs up and
    // stops taking sample requests.
    initial
    begin : receiver
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                result_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_stall_req = 1'b0;
            end
            else if (calm || free_left > 0)
            begin
                result_ready = 1'b1;
                if (free_left > 0)
                    free_left--;
            end
            else if (stall_left > 0)
            begin
                result_ready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                result_ready = 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
            begin
                result_ready = 1'b1;
                if ($urandom_range(0, 40) == 0)
                    free_left = $urandom_range(30, 80);
            end
        end
    end

    // Offers one sample request and returns at the falling edge after it was
    // accepted. The caller is always at a falling edge when it calls, so every
    // decision it takes already sees the predictor updated for earlier requests.
    // Valid stays high into the next call, so back-to-back requests keep it high.
    task automatic send_sample(input logic [7:0] ch, input logic lvl);
        int gap;
        gap = 0;
        if (!calm && !long_stall_req && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 9);
        repeat (gap)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample.channel = ch;
        sample.raw_level = lvl;
        do
            @(posedge clk);
        while (!sample_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Stops offering requests until every predicted result has come back, then
    // lets the pipeline settle.
    task automatic wait_drained();
        sample_valid = 1'b0;
        while (chk.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // The threshold only changes while the block is empty.
    task automatic write_threshold(input logic [7:0] value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        chk.threshold = value;
    endtask

    // Random traffic for one threshold setting. Most of it is runs of steady
    // samples on one channel, aimed away from the channel's current level and
    // sized around the threshold so that changes are confirmed, just missed, or
    // held past confirmation. With low thresholds, stray samples on random
    // channels (often out of range) are mixed in and may break runs as noise.
    // A run is cut short once the budget is spent.
    task automatic random_phase(input int budget);
        int         stop;
        int         len;
        int         pick;
        int         noise_pct;
        int         thr;
        logic [7:0] ch;
        logic       lvl;
        stop = items_sent + budget;
        thr = chk.threshold;
        noise_pct = (thr > 40) ? 0 : 15;
        while (items_sent < stop)
        begin
            ch = $urandom_range(0, CHANNEL_COUNT - 1);
            lvl = ($urandom_range(0, 4) == 0) ? chk.levels[ch] : ~chk.levels[ch];
            pick = $urandom_range(0, 9);
            if (pick < 4)
                len = thr + 1;
            else if (pick < 6)
                len = thr + 2 + $urandom_range(0, 3);
            else if (pick < 8)
                len = (thr > 0) ? thr : 1;
            else
                len = $urandom_range(1, 3);
            for (int i = 0; i < len && items_sent < stop; i++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_sample(8'($urandom_range(0, CHANNEL_COUNT - 1)),
                                    1'($urandom_range(0, 1)));
                    else
                        send_sample(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                send_sample(ch, lvl);
            end
        end
    endtask

    initial
    begin
        chk = new();
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        long_stall_req = 1'b0;
        calm = 1'b0;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset threshold: a rise that is cut short by noise, a rise left
        // pending, and out-of-range channels at the top and bottom of the range.
        send_sample(8'd0, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd7, 1'b1);
        send_sample(8'(CHANNEL_COUNT), 1'b1);
        send_sample(8'd255, 1'b1);
        send_sample(8'd128, 1'b0);

        // Zero threshold: each change is confirmed on the first steady sample
        // after the edge. Channel 1 rises, falls, bounces back high, then falls.
        write_threshold(8'd0);
        send_sample(8'd1, 1'b1);
        send_sample(8'd1, 1'b1);
        send_sample(8'd1, 1'b0);
        send_sample(8'd1, 1'b1);
        send_sample(8'd1, 1'b0);
        send_sample(8'd1, 1'b0);
        send_sample(8'd2, 1'b1);
        send_sample(8'd2, 1'b0);

        // Threshold of one: the counter left at one by the edge already meets it.
        write_threshold(8'd1);
        send_sample(8'd3, 1'b1);
        send_sample(8'd3, 1'b1);
        send_sample(8'd3, 1'b1);
        send_sample(8'd3, 1'b0);

        // Random part. The first phase starts with a long receiver hold-off
        // while requests keep coming, so the block fills and stalls its input.
        write_threshold(8'd3);
        long_stall_req = 1'b1;
        random_phase(350);
        write_threshold(8'd0);
        random_phase(200);
        write_threshold(8'd1);
        random_phase(200);
        // Largest threshold: runs of 256 samples take the counter to its bound.
        write_threshold(8'd255);
        random_phase(550);
        write_threshold(8'($urandom_range(2, 20)));
        random_phase(400);
        write_threshold(THRESHOLD_RESET);
        calm = 1'b1;
        random_phase(250);

        wait_drained();
        if (chk.errors == 0)
            $display("tb_multichannel_debounce_fsm: PASS");
        else
            $display("tb_multichannel_debounce_fsm: FAIL");
        $finish;
    end

endmodule

[multichannel_debounce_fsm.f]
sv/dbnc_pkg.sv
sv/dbnc_step.sv
sv/dbnc_chan_bank.sv
sv/multichannel_debounce_fsm.sv
tb/sv/tb_multichannel_debounce_fsm.sv
